// ===== sv/rsr_pkg.sv =====
// rsr_pkg: item types and constants for the replacement selection run generator.
// No dependencies.
`timescale 1ns / 1ps
package rsr_pkg;
   localparam int KEY_W        = 32;
   localparam int CSR_W        = 6;
   localparam int DEF_CAPACITY = 32;
   localparam logic [CSR_W-1:0] CSR_SIZE_RESET = 6'd32;

   typedef struct packed {
      logic signed [KEY_W-1:0] record_value;
      logic                    last_record;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] run_value;
      logic                    end_of_run;
      logic                    last_of_item;
   } rsp_type;
endpackage

// ===== sv/rsr_heap_ram.sv =====
// rsr_heap_ram: heap key storage, one write port, two registered read ports.
// Depends on rsr_pkg.
`timescale 1ns / 1ps
module rsr_heap_ram #(
   parameter int DEPTH = rsr_pkg::DEF_CAPACITY,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [AW-1:0]                     wr_addr,
   input  logic signed [rsr_pkg::KEY_W-1:0]  wr_data,
   input  logic [AW-1:0]                     rd_addr0,
   input  logic [AW-1:0]                     rd_addr1,
   output logic signed [rsr_pkg::KEY_W-1:0]  rd_data0,
   output logic signed [rsr_pkg::KEY_W-1:0]  rd_data1
);
   import rsr_pkg::*;

   logic signed [KEY_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
   end
endmodule

// ===== sv/replacement_selection_runs.sv =====
// Fill item: the record is pushed into the heap. Emitting item: the top is popped and
// emitted, and each frozen record is moved back into the heap when a run closes.
// Drain adds a pop per record. The block takes one item at a time; the single heap RAM
// port pair and the shared sift compare serve every step.
// Reset: synchronous, active high; clears counts and control, memory size returns to 32.
// Depends on rsr_pkg and rsr_heap_ram.
`timescale 1ns / 1ps
module replacement_selection_runs #(
   parameter int CAPACITY = rsr_pkg::DEF_CAPACITY
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rsr_pkg::req_type              req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rsr_pkg::rsp_type              rsp_item,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rsr_pkg::CSR_W-1:0]     csr_data
);
   import rsr_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_PUSH_RD  = 4'd1;
   localparam logic [3:0] S_PUSH_CMP = 4'd2;
   localparam logic [3:0] S_POP_RD   = 4'd3;
   localparam logic [3:0] S_POP_LD   = 4'd4;
   localparam logic [3:0] S_SD_RD    = 4'd5;
   localparam logic [3:0] S_SD_CMP   = 4'd6;
   localparam logic [3:0] S_PLACE    = 4'd7;
   localparam logic [3:0] S_AFTER    = 4'd8;
   localparam logic [3:0] S_THAW_RD  = 4'd9;
   localparam logic [3:0] S_THAW_LD  = 4'd10;
   localparam logic [3:0] S_EMIT     = 4'd11;
   localparam logic [3:0] S_CHK_LAST = 4'd12;

   localparam logic [1:0] CTX_FILL  = 2'd0;
   localparam logic [1:0] CTX_MAIN  = 2'd1;
   localparam logic [1:0] CTX_DRAIN = 2'd2;

   logic [3:0]              state_ff, state_in;
   logic [1:0]              ctx_ff, ctx_in;
   logic                    thaw_ff, thaw_in;
   logic                    eor_ff, eor_in;
   logic                    last_ff, last_in;
   logic signed [KEY_W-1:0] rec_ff, rec_in;
   logic signed [KEY_W-1:0] top_ff, top_in;
   logic signed [KEY_W-1:0] val_ff, val_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           hc_ff, hc_in;
   logic [CW-1:0]           fc_ff, fc_in;
   logic [CW-1:0]           tj_ff, tj_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [CSR_W-1:0]        csr_size_ff;

   logic signed [KEY_W-1:0] frz_mem [CAPACITY];
   logic signed [KEY_W-1:0] frz_rd_ff;
   logic                    frz_we;

   logic                    h_we;
   logic [AW-1:0]           h_waddr, h_raddr0, h_raddr1;
   logic signed [KEY_W-1:0] h_wdata, h_rd0, h_rd1;

   logic [CW-1:0]           size_eff;
   logic [CW:0]             mem_sum;
   logic [AW:0]             lch, rch;
   logic [AW-1:0]           par;
   logic                    take_l, take_r;
   logic signed [KEY_W-1:0] sd_min;
   logic [3:0]              push_done;

   rsr_heap_ram #(.DEPTH(CAPACITY), .AW(AW)) u_heap (
      .clock    (clock),
      .wr_en    (h_we),
      .wr_addr  (h_waddr),
      .wr_data  (h_wdata),
      .rd_addr0 (h_raddr0),
      .rd_addr1 (h_raddr1),
      .rd_data0 (h_rd0),
      .rd_data1 (h_rd1)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      if (csr_size_ff == '0) begin
         size_eff = CW'(1);
      end else if (csr_size_ff > CSR_W'(CAPACITY)) begin
         size_eff = CW'(CAPACITY);
      end else begin
         size_eff = CW'(csr_size_ff);
      end
   end

   assign mem_sum = {1'b0, hc_ff} + {1'b0, fc_ff};
   assign lch     = {idx_ff, 1'b1};
   assign rch     = lch + (AW+1)'(1);
   assign par     = (idx_ff - AW'(1)) >> 1;
   // sift-down child choice, ties keep the parent
   assign take_l  = (lch < (AW+1)'(hc_ff)) && (h_rd0 < val_ff);
   assign sd_min  = take_l ? h_rd0 : val_ff;
   assign take_r  = (rch < (AW+1)'(hc_ff)) && (h_rd1 < sd_min);
   assign push_done = thaw_ff ? S_THAW_RD : ((ctx_ff == CTX_FILL) ? S_CHK_LAST : S_AFTER);

   always_comb begin
      state_in     = state_ff;
      ctx_in       = ctx_ff;
      thaw_in      = thaw_ff;
      eor_in       = eor_ff;
      last_in      = last_ff;
      rec_in       = rec_ff;
      top_in       = top_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      hc_in        = hc_ff;
      fc_in        = fc_ff;
      tj_in        = tj_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      h_we         = 1'b0;
      h_waddr      = idx_ff;
      h_wdata      = val_ff;
      h_raddr0     = '0;
      h_raddr1     = '0;
      frz_we       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rec_in  = req_item.record_value;
               last_in = req_item.last_record;
               eor_in  = 1'b0;
               thaw_in = 1'b0;
               if (mem_sum < {1'b0, size_eff}) begin
                  ctx_in   = CTX_FILL;
                  val_in   = req_item.record_value;
                  idx_in   = AW'(hc_ff);
                  hc_in    = hc_ff + CW'(1);
                  state_in = S_PUSH_RD;
               end else begin
                  ctx_in = CTX_MAIN;
                  if (hc_ff == '0) begin
                     thaw_in  = 1'b1;
                     tj_in    = '0;
                     state_in = S_THAW_RD;
                  end else begin
                     state_in = S_POP_RD;
                  end
               end
            end
         end
         S_PUSH_RD: begin
            h_raddr0 = par;
            if (idx_ff == '0) begin
               h_we     = 1'b1;
               state_in = push_done;
            end else begin
               state_in = S_PUSH_CMP;
            end
         end
         S_PUSH_CMP: begin
            h_we = 1'b1;
            if (val_ff < h_rd0) begin
               h_wdata  = h_rd0;
               idx_in   = par;
               state_in = S_PUSH_RD;
            end else begin
               state_in = push_done;
            end
         end
         S_POP_RD: begin
            h_raddr1 = AW'(hc_ff - CW'(1));
            state_in = S_POP_LD;
         end
         S_POP_LD: begin
            top_in   = h_rd0;
            val_in   = h_rd1;
            hc_in    = hc_ff - CW'(1);
            idx_in   = '0;
            state_in = S_SD_RD;
         end
         S_SD_RD: begin
            h_raddr0 = AW'(lch);
            h_raddr1 = AW'(rch);
            if (lch < (AW+1)'(hc_ff)) begin
               state_in = S_SD_CMP;
            end else begin
               h_we     = 1'b1;
               state_in = (ctx_ff == CTX_MAIN) ? S_PLACE : S_AFTER;
            end
         end
         S_SD_CMP: begin
            h_we = 1'b1;
            if (take_r) begin
               h_wdata  = h_rd1;
               idx_in   = AW'(rch);
               state_in = S_SD_RD;
            end else if (take_l) begin
               h_wdata  = h_rd0;
               idx_in   = AW'(lch);
               state_in = S_SD_RD;
            end else begin
               state_in = (ctx_ff == CTX_MAIN) ? S_PLACE : S_AFTER;
            end
         end
         S_PLACE: begin
            if (!(rec_ff < top_ff)) begin
               val_in   = rec_ff;
               idx_in   = AW'(hc_ff);
               hc_in    = hc_ff + CW'(1);
               state_in = S_PUSH_RD;
            end else begin
               frz_we   = 1'b1;
               fc_in    = fc_ff + CW'(1);
               state_in = S_AFTER;
            end
         end
         S_AFTER: begin
            if (hc_ff == '0) begin
               eor_in   = 1'b1;
               thaw_in  = 1'b1;
               tj_in    = '0;
               state_in = S_THAW_RD;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_THAW_RD: begin
            if (tj_ff < fc_ff) begin
               state_in = S_THAW_LD;
            end else begin
               fc_in    = '0;
               thaw_in  = 1'b0;
               state_in = eor_ff ? S_EMIT : S_POP_RD;
            end
         end
         S_THAW_LD: begin
            val_in   = frz_rd_ff;
            idx_in   = AW'(hc_ff);
            hc_in    = hc_ff + CW'(1);
            tj_in    = tj_ff + CW'(1);
            state_in = S_PUSH_RD;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.run_value    = top_ff;
               rsp_in.end_of_run   = eor_ff;
               rsp_in.last_of_item = !last_ff || (hc_ff == '0);
               rsp_valid_in        = 1'b1;
               state_in            = S_CHK_LAST;
            end
         end
         S_CHK_LAST: begin
            if (last_ff && (hc_ff != '0)) begin
               ctx_in   = CTX_DRAIN;
               eor_in   = 1'b0;
               state_in = S_POP_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ctx_ff       <= CTX_FILL;
         thaw_ff      <= 1'b0;
         eor_ff       <= 1'b0;
         last_ff      <= 1'b0;
         hc_ff        <= '0;
         fc_ff        <= '0;
         tj_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         csr_size_ff  <= CSR_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         ctx_ff       <= ctx_in;
         thaw_ff      <= thaw_in;
         eor_ff       <= eor_in;
         last_ff      <= last_in;
         hc_ff        <= hc_in;
         fc_ff        <= fc_in;
         tj_ff        <= tj_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            csr_size_ff <= csr_data;
         end
      end
      rec_ff <= rec_in;
      top_ff <= top_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (frz_we) begin
         frz_mem[AW'(fc_ff)] <= rec_ff;
      end
      frz_rd_ff <= frz_mem[AW'(tj_ff)];
   end

   // frozen count is cleared only once the thaw pass ends
   a_mem_bound: assert property (@(posedge clock) disable iff (reset)
      !thaw_ff |-> mem_sum <= (CW+1)'(CAPACITY))
      else $error("heap plus frozen exceeds capacity");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP_RD |-> hc_ff != '0)
      else $error("pop from empty heap");

   a_sift_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SD_RD |-> (idx_ff == '0 || (CW+1)'(idx_ff) < (CW+1)'(hc_ff)))
      else $error("sift index beyond heap");

   a_emit_open_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !eor_ff) |-> hc_ff != '0)
      else $error("run left open with empty heap");
endmodule
